// ----- rtl/core/sft_pkg.sv -----
// ----------------------------------------------------------------------------
// sft_pkg: shared types and codes of the sprite frame timeline
// Operation and status codes, field widths and the sequencer state type.
// ----------------------------------------------------------------------------
package sft_pkg;

    localparam int TIME_W   = 20;
    localparam int REQ_W    = 32;
    localparam int FIELD_DUR_W = 16;
    localparam int IDX_IN_W = 16;
    localparam int DEPTH_W  = 3;
    localparam int OP_W     = 2;
    localparam int STAT_W   = 2;
    localparam int FRAME_OUT_W = 4;

    localparam logic [TIME_W-1:0] TIME_LIMIT = '1;

    localparam logic [OP_W-1:0] OP_ADD_FRAME = 2'd0;
    localparam logic [OP_W-1:0] OP_SET_TIME  = 2'd1;
    localparam logic [OP_W-1:0] OP_SET_INDEX = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD_DEPTH = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

    localparam logic CFG_LOOP_MODE    = 1'b0;
    localparam logic CFG_SPRITE_DEPTH = 1'b1;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_EXEC   = 6'b000010,
        S_DIV    = 6'b000100,
        S_PREP   = 6'b001000,
        S_WALK   = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

endpackage

// ----- rtl/core/sft_ram.sv -----
// ----------------------------------------------------------------------------
// sft_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sft_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                       aclk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/sprite_frame_timeline.sv -----
// ----------------------------------------------------------------------------
// sprite_frame_timeline: animation timeline of one sprite
// Frame duration table in RAM, time wrap via a serial divider, table walk.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request per transaction (add frame, set time, set
//   frame index); m_axis returns exactly one status transaction per request,
//   in order. The configuration port sets loop mode and the sprite depth code
//   and the user must write it only while no request is in flight, which the
//   block itself does not enforce.
// Sequence (one request at a time): add frame, plain set index and an unused
//   opcode execute and finish; a set index that wraps first runs the 32-step
//   divider by the frame count. Set time walks N table entries (at most
//   MAX_FRAMES), after the divider when it wraps. The wrap runs one quotient bit
//   per cycle; the walk reads one duration per cycle from the table RAM.
// Reset: the timeline is empty, no frame is selected, time is zero, loop mode
//   is on and the sprite depth code is zero. Table contents are not cleared;
//   only entries below the frame count are ever used.
// Stall: a finished result waits in the output register; the next request is
//   accepted meanwhile and its result holds until the receiver takes the
//   pending one.
// ----------------------------------------------------------------------------
module sprite_frame_timeline #(
    parameter int MAX_FRAMES    = 16,
    parameter int DURATION_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_addr,
    input  logic [2:0]  cfg_wdata,
    // requests
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: opcode[1:0], frame_duration[17:2], frame_depth[20:18],
    //        time_value[52:21], index_value[68:53], zero fill [71:69]
    input  logic [71:0] s_axis_tdata,
    // results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: status[1:0], frame_selected[2], current_frame[6:3],
    //        play_time[26:7], zero fill [31:27]
    output logic [31:0] m_axis_tdata
);
    localparam int AW    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_W = $clog2(MAX_FRAMES + 1);
    localparam int DUR_W = (DURATION_BITS < sft_pkg::FIELD_DUR_W) ?
                           DURATION_BITS : sft_pkg::FIELD_DUR_W;
    localparam int TW    = sft_pkg::TIME_W;
    localparam int RW    = sft_pkg::REQ_W;

    // Unpack the request
    logic [sft_pkg::OP_W-1:0]        in_opcode;
    logic [sft_pkg::FIELD_DUR_W-1:0] in_duration;
    logic [sft_pkg::DEPTH_W-1:0]     in_depth;
    logic [RW-1:0]                   in_time;
    logic [sft_pkg::IDX_IN_W-1:0]    in_index;

    assign in_opcode   = s_axis_tdata[1:0];
    assign in_duration = s_axis_tdata[17:2];
    assign in_depth    = s_axis_tdata[20:18];
    assign in_time     = s_axis_tdata[52:21];
    assign in_index    = s_axis_tdata[68:53];

    // Control and timeline state
    sft_pkg::state_t state_reg, state_next;
    logic             loop_mode_reg, loop_mode_next;
    logic [2:0]       sprite_depth_reg, sprite_depth_next;
    logic [CNT_W-1:0] frame_count_reg, frame_count_next;
    logic [TW-1:0]    total_time_reg, total_time_next;
    logic [TW-1:0]    time_now_reg, time_now_next;
    logic [AW-1:0]    sel_frame_reg, sel_frame_next;
    logic             sel_valid_reg, sel_valid_next;
    logic             m_valid_reg, m_valid_next;
    logic [31:0]      m_data_reg, m_data_next;
    logic [sft_pkg::STAT_W-1:0] status_reg, status_next;

    // Latched request (payload, no reset)
    logic [sft_pkg::OP_W-1:0]        op_reg;
    logic [DUR_W-1:0]                dur_reg;
    logic [sft_pkg::DEPTH_W-1:0]     depth_reg;
    logic [RW-1:0]                   tval_reg;
    logic [sft_pkg::IDX_IN_W-1:0]    ival_reg;

    // Serial divider and table walk
    logic [RW-1:0]    dvd_reg, dvd_next;
    logic [TW-1:0]    dsr_reg, dsr_next;
    logic [TW-1:0]    rem_reg, rem_next;
    logic [4:0]       div_cnt_reg, div_cnt_next;
    logic [TW-1:0]    rest_reg, rest_next;
    logic [AW-1:0]    walk_idx_reg, walk_idx_next;

    logic [TW:0]      trial;
    logic [TW:0]      trial_sub;
    logic [TW-1:0]    rem_step;
    logic [TW:0]      sum_total;
    logic [TW-1:0]    entry;
    logic             walk_last;
    logic [31:0]      sel_ext;

    // Table RAM
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [AW-1:0]    ram_raddr;
    logic [DUR_W-1:0] ram_rdata;

    sft_ram #(
        .WIDTH (DUR_W),
        .DEPTH (MAX_FRAMES)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (dur_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_axis_tready = (state_reg == sft_pkg::S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // One restoring divider step: shift in the next dividend bit
    assign trial     = {rem_reg, dvd_reg[RW-1]};
    assign trial_sub = trial - {1'b0, dsr_reg};
    assign rem_step  = (trial >= {1'b0, dsr_reg}) ? trial_sub[TW-1:0] : trial[TW-1:0];

    assign sum_total = {1'b0, total_time_reg} + (TW+1)'(dur_reg);
    assign entry     = TW'(ram_rdata);
    assign walk_last = ((CNT_W'(walk_idx_reg) + CNT_W'(1)) == frame_count_reg);
    assign sel_ext   = 32'(sel_frame_reg);

    assign ram_waddr = frame_count_reg[AW-1:0];

    always_comb begin
        state_next        = state_reg;
        loop_mode_next    = loop_mode_reg;
        sprite_depth_next = sprite_depth_reg;
        frame_count_next  = frame_count_reg;
        total_time_next   = total_time_reg;
        time_now_next     = time_now_reg;
        sel_frame_next    = sel_frame_reg;
        sel_valid_next    = sel_valid_reg;
        m_valid_next      = m_valid_reg;
        m_data_next       = m_data_reg;
        status_next       = status_reg;
        dvd_next          = dvd_reg;
        dsr_next          = dsr_reg;
        rem_next          = rem_reg;
        div_cnt_next      = div_cnt_reg;
        rest_next         = rest_reg;
        walk_idx_next     = walk_idx_reg;
        ram_we            = 1'b0;
        ram_raddr         = '0;

        // Drop a result once the receiver takes it
        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_wr_en) begin
            case (cfg_addr)
                sft_pkg::CFG_LOOP_MODE:    loop_mode_next    = cfg_wdata[0];
                sft_pkg::CFG_SPRITE_DEPTH: sprite_depth_next = cfg_wdata;
                default: ;
            endcase
        end

        case (state_reg)
            sft_pkg::S_IDLE: begin
                if (s_axis_tvalid) begin
                    state_next = sft_pkg::S_EXEC;
                end
            end

            sft_pkg::S_EXEC: begin
                status_next = sft_pkg::ST_OK;
                state_next  = sft_pkg::S_FINISH;
                case (op_reg)
                    sft_pkg::OP_ADD_FRAME: begin
                        if (depth_reg != sprite_depth_reg) begin
                            status_next = sft_pkg::ST_BAD_DEPTH;
                        end else if (frame_count_reg >= CNT_W'(MAX_FRAMES)) begin
                            status_next = sft_pkg::ST_FULL;
                        end else begin
                            ram_we           = 1'b1;
                            frame_count_next = frame_count_reg + CNT_W'(1);
                            total_time_next  = sum_total[TW] ? sft_pkg::TIME_LIMIT
                                                             : sum_total[TW-1:0];
                            if (!sel_valid_reg) begin
                                sel_frame_next = '0;
                                sel_valid_next = 1'b1;
                            end
                        end
                    end
                    sft_pkg::OP_SET_TIME: begin
                        if (tval_reg > RW'(total_time_reg)) begin
                            if (loop_mode_reg && (total_time_reg != '0)) begin
                                // Wrap into (0, total]: divide t-1 by total
                                dvd_next     = tval_reg - RW'(1);
                                dsr_next     = total_time_reg;
                                rem_next     = '0;
                                div_cnt_next = '0;
                                state_next   = sft_pkg::S_DIV;
                            end else begin
                                // Clamp, or an empty looping animation gives zero
                                time_now_next = loop_mode_reg ? '0 : total_time_reg;
                                rest_next     = loop_mode_reg ? '0 : total_time_reg;
                                state_next    = (frame_count_reg != '0) ?
                                                sft_pkg::S_PREP : sft_pkg::S_FINISH;
                            end
                        end else begin
                            time_now_next = tval_reg[TW-1:0];
                            rest_next     = tval_reg[TW-1:0];
                            state_next    = (frame_count_reg != '0) ?
                                            sft_pkg::S_PREP : sft_pkg::S_FINISH;
                        end
                    end
                    sft_pkg::OP_SET_INDEX: begin
                        if (frame_count_reg != '0) begin
                            if (ival_reg >= sft_pkg::IDX_IN_W'(frame_count_reg)) begin
                                if (loop_mode_reg) begin
                                    dvd_next     = RW'(ival_reg);
                                    dsr_next     = TW'(frame_count_reg);
                                    rem_next     = '0;
                                    div_cnt_next = '0;
                                    state_next   = sft_pkg::S_DIV;
                                end
                            end else begin
                                sel_frame_next = ival_reg[AW-1:0];
                                sel_valid_next = 1'b1;
                            end
                        end
                    end
                    default: ;
                endcase
            end

            sft_pkg::S_DIV: begin
                rem_next     = rem_step;
                dvd_next     = {dvd_reg[RW-2:0], 1'b0};
                div_cnt_next = div_cnt_reg + 5'd1;
                if (div_cnt_reg == 5'd31) begin
                    if (op_reg == sft_pkg::OP_SET_TIME) begin
                        // Remainder below total, so +1 stays within the field
                        time_now_next = rem_step + TW'(1);
                        rest_next     = rem_step + TW'(1);
                        state_next    = sft_pkg::S_PREP;
                    end else begin
                        sel_frame_next = rem_step[AW-1:0];
                        sel_valid_next = 1'b1;
                        state_next     = sft_pkg::S_FINISH;
                    end
                end
            end

            sft_pkg::S_PREP: begin
                // Issue the read of the first duration
                ram_raddr     = '0;
                walk_idx_next = '0;
                state_next    = sft_pkg::S_WALK;
            end

            sft_pkg::S_WALK: begin
                // Read ahead the next entry while this one is compared
                ram_raddr      = AW'(walk_idx_reg + AW'(1));
                sel_frame_next = walk_idx_reg;
                sel_valid_next = 1'b1;
                if ((rest_reg <= entry) || walk_last) begin
                    state_next = sft_pkg::S_FINISH;
                end else begin
                    rest_next     = rest_reg - entry;
                    walk_idx_next = AW'(walk_idx_reg + AW'(1));
                end
            end

            sft_pkg::S_FINISH: begin
                // Hold until the output register is free
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {5'd0, time_now_reg, sel_ext[3:0],
                                    sel_valid_reg, status_reg};
                    state_next   = sft_pkg::S_IDLE;
                end
            end

            default: state_next = sft_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= sft_pkg::S_IDLE;
            loop_mode_reg    <= 1'b1;
            sprite_depth_reg <= '0;
            frame_count_reg  <= '0;
            total_time_reg   <= '0;
            time_now_reg     <= '0;
            sel_frame_reg    <= '0;
            sel_valid_reg    <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            loop_mode_reg    <= loop_mode_next;
            sprite_depth_reg <= sprite_depth_next;
            frame_count_reg  <= frame_count_next;
            total_time_reg   <= total_time_next;
            time_now_reg     <= time_now_next;
            sel_frame_reg    <= sel_frame_next;
            sel_valid_reg    <= sel_valid_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg   <= m_data_next;
        status_reg   <= status_next;
        dvd_reg      <= dvd_next;
        dsr_reg      <= dsr_next;
        rem_reg      <= rem_next;
        div_cnt_reg  <= div_cnt_next;
        rest_reg     <= rest_next;
        walk_idx_reg <= walk_idx_next;
        if (s_axis_tvalid && s_axis_tready) begin
            op_reg    <= in_opcode;
            dur_reg   <= in_duration[DUR_W-1:0];
            depth_reg <= in_depth;
            tval_reg  <= in_time;
            ival_reg  <= in_index;
        end
    end

endmodule

// ----- tb/tb_sprite_frame_timeline.sv -----
// ----------------------------------------------------------------------------
// tb_sprite_frame_timeline: self-checking bench for the sprite frame timeline
// Drives add-frame, set-time, set-index and unused requests through the
// request stream, tracks the timeline state in a scoreboard and checks every
// status transaction field by field. Loop mode and sprite depth change
// between phases while the block is idle. Both stream sides idle at random,
// and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_sprite_frame_timeline;

    localparam int NUM_FRAMES  = 16;
    localparam int CLK_HALF    = 6;
    localparam int CYCLE_LIMIT = 500000;
    localparam int RAND_PHASES = 6;
    localparam int PHASE_ITEMS = 140;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_GAP  = 60;

    // opcode 3 is not decoded by the block; it must echo the state unchanged
    localparam logic [sft_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [sft_pkg::IDX_IN_W-1:0]    index_value;
        logic [sft_pkg::REQ_W-1:0]       time_value;
        logic [sft_pkg::DEPTH_W-1:0]     frame_depth;
        logic [sft_pkg::FIELD_DUR_W-1:0] frame_duration;
        logic [sft_pkg::OP_W-1:0]        opcode;
    } timeline_req_t;

    typedef struct packed {
        logic [sft_pkg::TIME_W-1:0]      play_time;
        logic [sft_pkg::FRAME_OUT_W-1:0] current_frame;
        logic                            frame_selected;
        logic [sft_pkg::STAT_W-1:0]      status;
    } timeline_status_t;

    // ------------------------------------------------------------------------
    // Scoreboard: mirrors the timeline state and queues the status that each
    // accepted request must produce.
    // ------------------------------------------------------------------------
    class timeline_tracker;
        logic [sft_pkg::FIELD_DUR_W-1:0] dur_table [NUM_FRAMES];
        logic [4:0]                      frame_count;
        logic [sft_pkg::TIME_W-1:0]      total_ms;
        logic [sft_pkg::TIME_W-1:0]      now_ms;
        logic [3:0]                      sel_frame;
        logic                            sel_valid;
        logic                            loop_on;
        logic [sft_pkg::DEPTH_W-1:0]     depth_code;
        timeline_status_t                due_status_q[$];
        int mismatches;
        int results_seen;
        int n_added, n_bad_depth, n_full;
        int n_set_time, n_wrapped, n_clamped, n_set_index, n_unused;

        function new();
            frame_count = '0;
            total_ms    = '0;
            now_ms      = '0;
            sel_frame   = '0;
            sel_valid   = 1'b0;
            loop_on     = 1'b1;
            depth_code  = '0;
            mismatches  = 0;
            results_seen = 0;
            n_added = 0; n_bad_depth = 0; n_full = 0;
            n_set_time = 0; n_wrapped = 0; n_clamped = 0;
            n_set_index = 0; n_unused = 0;
        endfunction

        function void write_reg(logic addr, logic [2:0] value);
            if (addr == sft_pkg::CFG_LOOP_MODE) begin
                loop_on = value[0];
            end else begin
                depth_code = value;
            end
        endfunction

        function void note_request(timeline_req_t r);
            timeline_status_t exp_st;
            logic [sft_pkg::TIME_W:0]     sum;
            logic [sft_pkg::REQ_W-1:0]    t;
            logic [sft_pkg::REQ_W-1:0]    rest;
            logic [sft_pkg::IDX_IN_W-1:0] idx;
            int i;
            exp_st.status = sft_pkg::ST_OK;
            case (r.opcode)
                sft_pkg::OP_ADD_FRAME: begin
                    // depth is checked before the table fill level
                    if (r.frame_depth != depth_code) begin
                        exp_st.status = sft_pkg::ST_BAD_DEPTH;
                        n_bad_depth++;
                    end else if (frame_count >= NUM_FRAMES) begin
                        exp_st.status = sft_pkg::ST_FULL;
                        n_full++;
                    end else begin
                        dur_table[frame_count] = r.frame_duration;
                        frame_count++;
                        sum = total_ms + r.frame_duration;
                        total_ms = (sum > sft_pkg::TIME_LIMIT) ? sft_pkg::TIME_LIMIT
                                                               : sum[sft_pkg::TIME_W-1:0];
                        if (!sel_valid) begin
                            sel_frame = '0;
                            sel_valid = 1'b1;
                        end
                        n_added++;
                    end
                end
                sft_pkg::OP_SET_TIME: begin
                    n_set_time++;
                    t = r.time_value;
                    if (t > total_ms) begin
                        if (loop_on) begin
                            t = (total_ms == 0) ? '0 : ((t - 1) % total_ms) + 1;
                            n_wrapped++;
                        end else begin
                            t = total_ms;
                            n_clamped++;
                        end
                    end
                    now_ms = t[sft_pkg::TIME_W-1:0];
                    rest = t;
                    for (i = 0; i < frame_count; i++) begin
                        sel_frame = 4'(i);
                        sel_valid = 1'b1;
                        if (rest <= dur_table[i]) break;
                        rest -= dur_table[i];
                    end
                end
                sft_pkg::OP_SET_INDEX: begin
                    n_set_index++;
                    idx = r.index_value;
                    if (frame_count != 0) begin
                        if (loop_on && idx >= frame_count) idx = idx % frame_count;
                        if (idx < frame_count) begin
                            sel_frame = idx[3:0];
                            sel_valid = 1'b1;
                        end
                    end
                end
                default: begin
                    n_unused++;
                end
            endcase
            exp_st.frame_selected = sel_valid;
            exp_st.current_frame  = sel_frame;
            exp_st.play_time      = now_ms;
            due_status_q.push_back(exp_st);
        endfunction

        function void check_status(logic [31:0] tdata);
            timeline_status_t got, exp_st;
            got = tdata[$bits(timeline_status_t)-1:0];
            results_seen++;
            if (due_status_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result %0d (tdata=%h) ", results_seen,
                             tdata, "with none pending");
                return;
            end
            exp_st = due_status_q.pop_front();
            if (got.status !== exp_st.status || got.frame_selected !== exp_st.frame_selected ||
                got.current_frame !== exp_st.current_frame ||
                got.play_time !== exp_st.play_time) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result %0d expected st=%0d sel=%0b frm=%0d t=%0d, ",
                             results_seen, exp_st.status, exp_st.frame_selected,
                             exp_st.current_frame, exp_st.play_time,
                             "got st=%0d sel=%0b frm=%0d t=%0d",
                             got.status, got.frame_selected, got.current_frame,
                             got.play_time);
            end
        endfunction

        function int pending();
            return due_status_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals, clock and the block
    // ------------------------------------------------------------------------
    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        cfg_wr_en     = 1'b0;
    logic [0:0]  cfg_addr      = '0;
    logic [2:0]  cfg_wdata     = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;

    timeline_tracker sb = new();

    int  cycle_count  = 0;
    bit  tx_quiet     = 1'b0;   // sender phase with no gaps
    bit  rx_quiet     = 1'b0;   // receiver stretch with no stalls
    bit  hold_off_req = 1'b0;   // ask the receiver for one long hold-off
    int  hold_offs    = 0;

    initial begin
        forever begin
            #CLK_HALF aclk = ~aclk;
        end
    end

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    sprite_frame_timeline u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic timeline_req_t make_req(logic [sft_pkg::OP_W-1:0] op,
                                               logic [15:0] dur, logic [2:0] depth,
                                               logic [31:0] tval, logic [15:0] ival);
        timeline_req_t r;
        r.opcode         = op;
        r.frame_duration = dur;
        r.frame_depth    = depth;
        r.time_value     = tval;
        r.index_value    = ival;
        return r;
    endfunction

    // Mostly short gaps, now and then a long one; none in a quiet phase.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (tx_quiet || roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Random request with content steered towards the interesting regions:
    // times around and beyond the total, small indexes, matching depths.
    function automatic timeline_req_t random_req();
        timeline_req_t r;
        int unsigned tot;
        int roll;
        tot = 32'(sb.total_ms);
        roll = $urandom_range(0, 99);
        if (roll < 22)      r.opcode = sft_pkg::OP_ADD_FRAME;
        else if (roll < 60) r.opcode = sft_pkg::OP_SET_TIME;
        else if (roll < 92) r.opcode = sft_pkg::OP_SET_INDEX;
        else                r.opcode = OP_UNUSED;
        case ($urandom_range(0, 7))
            0:       r.frame_duration = '0;
            1:       r.frame_duration = '1;
            2, 3:    r.frame_duration = 16'($urandom_range(1, 2000));
            default: r.frame_duration = 16'($urandom);
        endcase
        r.frame_depth = $urandom_range(0, 1) ? sb.depth_code : 3'($urandom);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: r.time_value = $urandom_range(0, tot + 2);
            5, 6:          r.time_value = $urandom_range(0, 3 * tot + 5);
            7:             r.time_value = $urandom;
            8:             r.time_value = tot + $urandom_range(0, 1);
            default:       r.time_value = $urandom_range(0, 3);
        endcase
        r.index_value = ($urandom_range(0, 9) < 6) ? 16'($urandom_range(0, 20))
                                                   : 16'($urandom);
        return r;
    endfunction

    // Offer one request and hold it until the block takes it, then note it.
    task automatic send_request(timeline_req_t r, int gap);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(72 - $bits(timeline_req_t)){1'b0}}, r};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        sb.note_request(r);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Drop valid and wait until every status has come back, plus some slack
    // so the block is certainly back in idle.
    task automatic drain_timeline();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic program_register(logic addr, logic [2:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge aclk);
        sb.write_reg(addr, value);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_directed(timeline_req_t r);
        send_request(r, pick_gap());
    endtask

    // ------------------------------------------------------------------------
    // Result side: check every transaction, stall at random, and serve one
    // long hold-off when the stimulus asks for it.
    // ------------------------------------------------------------------------
    initial begin
        int stall_left;
        int roll;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (m_axis_tvalid && m_axis_tready) sb.check_status(m_axis_tdata);
            if (cycle_count % 300 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_offs++;
                stall_left = HOLD_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                roll = $urandom_range(0, 99);
                if (!rx_quiet && roll < 20) begin
                    stall_left = (roll < 17) ? $urandom_range(0, 2) : $urandom_range(9, 49);
                    m_axis_tready <= 1'b0;
                end else begin
                    m_axis_tready <= 1'b1;
                end
            end
        end
    end

    // Watchdog: end the run if the traffic never completes.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("ERROR: timeout after %0d cycles, %0d results outstanding",
                 cycle_count, sb.pending());
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int p, n;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty timeline, looping: time wraps to zero, index is ignored.
        send_directed(make_req(sft_pkg::OP_SET_TIME, 16'h0000, 3'd0, 32'h0000_0000, 16'd0));
        send_directed(make_req(sft_pkg::OP_SET_TIME, 16'hFFFF, 3'd7, 32'hFFFF_FFFF, 16'hFFFF));
        send_directed(make_req(sft_pkg::OP_SET_INDEX, 16'h0000, 3'd0, 32'h0000_0000, 16'd5));
        send_directed(make_req(OP_UNUSED, 16'h1234, 3'd5, 32'hDEAD_BEEF, 16'hABCD));
        drain_timeline();

        // Empty timeline, clamping: time clamps to a zero total.
        program_register(sft_pkg::CFG_LOOP_MODE, 3'd0);
        send_directed(make_req(sft_pkg::OP_SET_TIME, 16'h0000, 3'd0, 32'hFFFF_FFFF, 16'd0));
        send_directed(make_req(sft_pkg::OP_SET_INDEX, 16'h0000, 3'd0, 32'h0000_0000, 16'd0));
        drain_timeline();

        // Highest depth code: a mismatch first, then frames of extreme length.
        program_register(sft_pkg::CFG_LOOP_MODE, 3'd1);
        program_register(sft_pkg::CFG_SPRITE_DEPTH, 3'd7);
        send_directed(make_req(sft_pkg::OP_ADD_FRAME, 16'd100, 3'd0, 32'h0, 16'd0));
        send_directed(make_req(sft_pkg::OP_ADD_FRAME, 16'h0000, 3'd7, 32'h0, 16'd0));
        send_directed(make_req(sft_pkg::OP_ADD_FRAME, 16'hFFFF, 3'd7, 32'h0, 16'd0));
        send_directed(make_req(sft_pkg::OP_ADD_FRAME, 16'h0001, 3'd7, 32'h0, 16'd0));
        // walk across the zero-length frame and the frame boundaries
        send_directed(make_req(sft_pkg::OP_SET_TIME, 16'h0, 3'd0, 32'd0, 16'd0));
        send_directed(make_req(sft_pkg::OP_SET_TIME, 16'h0, 3'd0, 32'd1, 16'd0));
        send_directed(make_req(sft_pkg::OP_SET_TIME, 16'h0, 3'd0, 32'd65535, 16'd0));
        send_directed(make_req(sft_pkg::OP_SET_TIME, 16'h0, 3'd0, 32'd65536, 16'd0));
        send_directed(make_req(sft_pkg::OP_SET_TIME, 16'h0, 3'd0, 32'd65537, 16'd0));
        send_directed(make_req(sft_pkg::OP_SET_TIME, 16'h0, 3'd0, 32'hFFFF_FFFF, 16'd0));
        // index in range, one past the end, and the largest index
        send_directed(make_req(sft_pkg::OP_SET_INDEX, 16'h0, 3'd0, 32'h0, 16'd2));
        send_directed(make_req(sft_pkg::OP_SET_INDEX, 16'h0, 3'd0, 32'h0, 16'd3));
        send_directed(make_req(sft_pkg::OP_SET_INDEX, 16'h0, 3'd0, 32'h0, 16'hFFFF));
        send_directed(make_req(OP_UNUSED, 16'hFFFF, 3'd7, 32'hFFFF_FFFF, 16'hFFFF));
        drain_timeline();

        // Clamping with frames: bad indexes are ignored, time clamps to total.
        program_register(sft_pkg::CFG_LOOP_MODE, 3'd0);
        send_directed(make_req(sft_pkg::OP_SET_INDEX, 16'h0, 3'd0, 32'h0, 16'd3));
        send_directed(make_req(sft_pkg::OP_SET_TIME, 16'h0, 3'd0, 32'hFFFF_FFFF, 16'd0));
        send_directed(make_req(sft_pkg::OP_SET_INDEX, 16'h0, 3'd0, 32'h0, 16'd1));
        send_directed(make_req(sft_pkg::OP_ADD_FRAME, 16'd5, 3'd7, 32'h0, 16'd0));
        send_directed(make_req(sft_pkg::OP_SET_TIME, 16'h0, 3'd0, 32'd65540, 16'd0));

        // Random phases, each under a fresh setting of both registers.
        for (p = 0; p < RAND_PHASES; p++) begin
            drain_timeline();
            program_register(sft_pkg::CFG_LOOP_MODE, {2'b0, p[0] == 1'b0});
            case (p)
                0:       program_register(sft_pkg::CFG_SPRITE_DEPTH, 3'd0);
                1:       program_register(sft_pkg::CFG_SPRITE_DEPTH, 3'd3);
                3:       program_register(sft_pkg::CFG_SPRITE_DEPTH, 3'd7);
                default: program_register(sft_pkg::CFG_SPRITE_DEPTH, 3'($urandom));
            endcase
            tx_quiet = (p == 3);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                // hold the result side off while requests keep coming
                if (p == 0 && n == 40) hold_off_req = 1'b1;
                // pause the sender until every status is back
                if (p == 1 && n == 70) drain_timeline();
                send_request(random_req(), pick_gap());
            end
        end

        drain_timeline();
        repeat (SETTLE_GAP) @(posedge aclk);

        $display("Covered %0d statuses: %0d frames added, %0d depth rejects, ",
                 sb.results_seen, sb.n_added, sb.n_bad_depth,
                 "%0d full rejects, %0d unused ops", sb.n_full, sb.n_unused);
        $display("Set time %0d (%0d wrapped, %0d clamped), set index %0d, ",
                 sb.n_set_time, sb.n_wrapped, sb.n_clamped, sb.n_set_index,
                 "long hold-offs %0d", hold_offs);
        if (sb.mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
